### src/sks_pkg.sv
// Shared types, constants and codes for the sorted key set.
// Used by sks_cell and sorted_key_set; no other dependencies.
`default_nettype none
package sks_pkg;

   localparam int CAPACITY = 32;
   localparam int KEY_W    = 32;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);

   localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SEARCH    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LIST_ASC  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LIST_DESC = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_FAIL = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic signed [KEY_W-1:0] key_out;
      logic                    last;
   } rsp_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic                    ins;
      logic                    del;
      logic signed [KEY_W-1:0] key;
   } cell_cmd_type;

endpackage
`default_nettype wire

### src/sks_cell.sv
// One storage cell of the sorted chain: holds a key, compares it with the
// broadcast key and shifts toward either neighbor. Depends on sks_pkg.
`default_nettype none
module sks_cell (
   input  wire logic                             clock,
   input  wire sks_pkg::cell_cmd_type            cmd,
   input  wire logic                             valid_i,
   input  wire logic                             prev_lt,
   input  wire logic signed [sks_pkg::KEY_W-1:0] prev_key,
   input  wire logic signed [sks_pkg::KEY_W-1:0] next_key,
   output logic signed [sks_pkg::KEY_W-1:0]      key_o,
   output logic                                  lt_o,
   output logic                                  eq_o
);

   logic signed [sks_pkg::KEY_W-1:0] key_ff;
   logic signed [sks_pkg::KEY_W-1:0] key_in;

   assign lt_o  = valid_i && ($signed(key_ff) < $signed(cmd.key));
   assign eq_o  = valid_i && (key_ff == cmd.key);
   assign key_o = key_ff;

   // Stored keys form a sorted prefix, so the cells below the key make a
   // prefix too; the first cell outside it is the insertion point.
   always_comb begin
      key_in = key_ff;
      if (cmd.ins && !lt_o) begin
         key_in = prev_lt ? cmd.key : prev_key;
      end else if (cmd.del && !lt_o) begin
         key_in = next_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule
`default_nettype wire

### src/sorted_key_set.sv
// Sorted key set: a chain of comparing cells that holds distinct signed keys
// ascending. A request is registered when it is accepted in IDLE; its result is
// registered in EXEC once the output register is free. The request side stalls
// outside IDLE, so a new request is taken only after the last one is through.
// A listing of n keys gives n results, one per cycle while the receiver does not stall.
// Reset clears the entry count and control; stored keys are not cleared.
`default_nettype none
module sorted_key_set (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sks_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sks_pkg::rsp_type      rsp_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_LIST = 2'd2;

   logic [1:0]                state_ff, state_in;
   sks_pkg::req_type          op_ff, op_in;
   logic [sks_pkg::CNT_W-1:0] count_ff, count_in;
   logic [sks_pkg::CNT_W-1:0] lcnt_ff, lcnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   sks_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   sks_pkg::cell_cmd_type            cmd;
   logic signed [sks_pkg::KEY_W-1:0] cell_key [sks_pkg::CAPACITY];
   logic [sks_pkg::CAPACITY-1:0]     cell_lt;
   logic [sks_pkg::CAPACITY-1:0]     cell_eq;

   logic                      req_accept;
   logic                      rsp_free;
   logic                      hit;
   logic                      full;
   logic                      list_last;
   logic [sks_pkg::CNT_W-1:0] desc_pos;
   logic [sks_pkg::IDX_W-1:0] list_idx;

   // The request side is open only while the control is idle; the output
   // register is free when it is empty or its result is taken this cycle.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign hit  = |cell_eq;
   assign full = (count_ff == sks_pkg::CNT_W'(sks_pkg::CAPACITY));

   // Listing walks the chain by a counter; descending reads it from the top.
   assign list_last = (lcnt_ff == count_ff - sks_pkg::CNT_W'(1));
   assign desc_pos  = count_ff - sks_pkg::CNT_W'(1) - lcnt_ff;
   assign list_idx  = (op_ff.kind == sks_pkg::KIND_LIST_ASC) ?
                      lcnt_ff[sks_pkg::IDX_W-1:0] : desc_pos[sks_pkg::IDX_W-1:0];

   // The chain of cells. Cell zero is always at or past the insertion point
   // when it is not below the key, so it sees a true left neighbor flag.
   for (genvar i = 0; i < sks_pkg::CAPACITY; i++) begin : g_cell
      logic                             valid_w;
      logic                             prev_lt_w;
      logic signed [sks_pkg::KEY_W-1:0] prev_key_w;
      logic signed [sks_pkg::KEY_W-1:0] next_key_w;

      assign valid_w = (count_ff > sks_pkg::CNT_W'(i));

      if (i == 0) begin : g_first
         assign prev_lt_w  = 1'b1;
         assign prev_key_w = cmd.key;
      end else begin : g_mid
         assign prev_lt_w  = cell_lt[i-1];
         assign prev_key_w = cell_key[i-1];
      end

      if (i == sks_pkg::CAPACITY - 1) begin : g_last
         assign next_key_w = cell_key[i];
      end else begin : g_body
         assign next_key_w = cell_key[i+1];
      end

      sks_cell u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .valid_i  (valid_w),
         .prev_lt  (prev_lt_w),
         .prev_key (prev_key_w),
         .next_key (next_key_w),
         .key_o    (cell_key[i]),
         .lt_o     (cell_lt[i]),
         .eq_o     (cell_eq[i])
      );
   end

   // Control: IDLE takes a request, EXEC compares and shifts the chain and
   // writes one result (or starts a listing), LIST emits stored keys.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      lcnt_in      = lcnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cmd.ins      = 1'b0;
      cmd.del      = 1'b0;
      cmd.key      = op_ff.key;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in    = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (rsp_free) begin
               rsp_data_in.status  = sks_pkg::STATUS_FAIL;
               rsp_data_in.key_out = '0;
               rsp_data_in.last    = 1'b1;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
               unique case (op_ff.kind)
                  sks_pkg::KIND_INSERT: begin
                     if (!hit && full) begin
                        rsp_data_in.status = sks_pkg::STATUS_FULL;
                     end else if (!hit) begin
                        rsp_data_in.status = sks_pkg::STATUS_OK;
                        cmd.ins            = 1'b1;
                        count_in           = count_ff + sks_pkg::CNT_W'(1);
                     end
                  end
                  sks_pkg::KIND_DELETE: begin
                     if (hit) begin
                        rsp_data_in.status = sks_pkg::STATUS_OK;
                        cmd.del            = 1'b1;
                        count_in           = count_ff - sks_pkg::CNT_W'(1);
                     end
                  end
                  sks_pkg::KIND_SEARCH: begin
                     if (hit) begin
                        rsp_data_in.status = sks_pkg::STATUS_OK;
                     end
                  end
                  sks_pkg::KIND_LIST_ASC, sks_pkg::KIND_LIST_DESC: begin
                     // A nonempty store is walked in LIST; an empty one
                     // gives the single failure result written above.
                     if (count_ff != '0) begin
                        rsp_valid_in = rsp_valid_ff && rsp_stall;
                        rsp_data_in  = rsp_data_ff;
                        lcnt_in      = '0;
                        state_in     = ST_LIST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LIST: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.status  = sks_pkg::STATUS_OK;
               rsp_data_in.key_out = cell_key[list_idx];
               rsp_data_in.last    = list_last;
               lcnt_in             = lcnt_ff + sks_pkg::CNT_W'(1);
               if (list_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      lcnt_ff     <= lcnt_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sks_pkg::CNT_W'(sks_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_count_only_exec: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (count_ff != $past(count_ff)) |-> $past(state_ff) == ST_EXEC)
      else $error("entry count changed outside the execute step");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_EXEC)
      else $error("accepted request did not reach the execute step");

   a_not_last_is_list: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.last |-> rsp_data_ff.status == sks_pkg::STATUS_OK)
      else $error("non-final result that is not a listed key");
`endif

endmodule
`default_nettype wire

### test/tb_sorted_key_set.sv
// Self-checking testbench for sorted_key_set: a directed table, then random
// set operations with random idling on both channels, all checked in order.
// Depends on sks_pkg and sorted_key_set only.
`timescale 1ns / 1ps

module tb_sorted_key_set;

   // Kind codes that the block does not define. They must still answer with
   // a single failed result and leave the store alone.
   localparam logic [sks_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [sks_pkg::KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
   localparam logic [sks_pkg::KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

   // Total requests of the run, directed rows included. Random rounds stop
   // issuing new work once this is reached, so the run ends a little above.
   localparam int ITEM_BUDGET   = 200;
   localparam int MAX_WAIT      = 17;
   localparam int SETTLE_CYCLES = 16;
   // Worst case is roughly 230 requests, each listing 32 keys with every
   // result stalled for MAX_WAIT. CYCLE_LIMIT is well above that.
   localparam int CYCLE_LIMIT   = 1_000_000;

   localparam logic signed [sks_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [sks_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   // One line of the directed table. When checked_by_hand is set, the
   // expected status is the one typed into the row; otherwise the set
   // model supplies every expected result.
   typedef struct {
      logic [sks_pkg::KIND_W-1:0]       kind;
      logic signed [sks_pkg::KEY_W-1:0] key;
      bit                               checked_by_hand;
      logic [sks_pkg::STATUS_W-1:0]     status;
   } plan_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   sks_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   sks_pkg::rsp_type rsp_data;

   // Software copy of the set, held ascending like the block's chain.
   logic signed [sks_pkg::KEY_W-1:0] model_keys[$];
   // Results predicted for the request just accepted.
   sks_pkg::rsp_type                 fresh_results[$];
   // Results predicted but not yet seen on the result channel, oldest first.
   sks_pkg::rsp_type                 awaited_results[$];
   plan_row_type                     directed_plan[$];

   int requests_sent = 0;
   int results_seen  = 0;
   int mismatches    = 0;
   int fills         = 0;
   int full_rejects  = 0;
   int cycle_count   = 0;
   int stall_left    = 0;
   bit pace_random   = 1'b1;

   sorted_key_set u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic sks_pkg::rsp_type make_rsp(
         input logic [sks_pkg::STATUS_W-1:0] status,
         input logic signed [sks_pkg::KEY_W-1:0] key_out,
         input logic last);
      sks_pkg::rsp_type r;
      r.status  = status;
      r.key_out = key_out;
      r.last    = last;
      return r;
   endfunction

   // Applies one request to the software set and queues the results it
   // causes in fresh_results. The lookup finds the first stored key that is
   // not below the operand, as the hardware chain compares in parallel.
   function automatic void predict_set_op(input sks_pkg::req_type r);
      logic signed [sks_pkg::KEY_W-1:0] k;
      int pos;
      int n;
      bit hit;
      k = r.key;
      n = model_keys.size();
      pos = 0;
      while (pos < n && model_keys[pos] < k) pos++;
      hit = (pos < n) && (model_keys[pos] == k);
      fresh_results = {};
      case (r.kind)
         sks_pkg::KIND_SEARCH: begin
            fresh_results.push_back(make_rsp(hit ? sks_pkg::STATUS_OK : sks_pkg::STATUS_FAIL,
                                             '0, 1'b1));
         end
         sks_pkg::KIND_DELETE: begin
            if (hit) model_keys.delete(pos);
            fresh_results.push_back(make_rsp(hit ? sks_pkg::STATUS_OK : sks_pkg::STATUS_FAIL,
                                             '0, 1'b1));
         end
         sks_pkg::KIND_INSERT: begin
            // A duplicate is refused before the capacity check, so a
            // duplicate into a full store reports a plain failure.
            if (hit) begin
               fresh_results.push_back(make_rsp(sks_pkg::STATUS_FAIL, '0, 1'b1));
            end else if (n >= sks_pkg::CAPACITY) begin
               full_rejects++;
               fresh_results.push_back(make_rsp(sks_pkg::STATUS_FULL, '0, 1'b1));
            end else begin
               model_keys.insert(pos, k);
               if (model_keys.size() == sks_pkg::CAPACITY) fills++;
               fresh_results.push_back(make_rsp(sks_pkg::STATUS_OK, '0, 1'b1));
            end
         end
         sks_pkg::KIND_LIST_ASC, sks_pkg::KIND_LIST_DESC: begin
            if (n == 0) begin
               fresh_results.push_back(make_rsp(sks_pkg::STATUS_FAIL, '0, 1'b1));
            end else begin
               for (int i = 0; i < n; i++) begin
                  fresh_results.push_back(make_rsp(sks_pkg::STATUS_OK,
                     model_keys[(r.kind == sks_pkg::KIND_LIST_ASC) ? i : n - 1 - i],
                     i == n - 1));
               end
            end
         end
         default: begin
            fresh_results.push_back(make_rsp(sks_pkg::STATUS_FAIL, '0, 1'b1));
         end
      endcase
   endfunction

   // Keys are biased toward a narrow band around zero and the extremes so
   // that duplicates and hits happen often; the rest are full-width random.
   // With from_store set, a key already in the set is returned if any.
   function automatic logic signed [sks_pkg::KEY_W-1:0] draw_key(input bit from_store);
      if (from_store && model_keys.size() != 0)
         return model_keys[$urandom_range(0, model_keys.size() - 1)];
      case ($urandom_range(0, 7))
         0: return KEY_MIN;
         1: return KEY_MAX;
         2: return '0;
         3: return $signed($urandom_range(0, 15)) - 8;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_row(input logic [sks_pkg::KIND_W-1:0] kind,
                          input logic signed [sks_pkg::KEY_W-1:0] key,
                          input bit checked_by_hand,
                          input logic [sks_pkg::STATUS_W-1:0] status);
      plan_row_type row;
      row.kind            = kind;
      row.key             = key;
      row.checked_by_hand = checked_by_hand;
      row.status          = status;
      directed_plan.push_back(row);
   endtask

   // Presents one request after a random gap and holds it until accepted.
   // The gap lowers valid on one falling edge and raises it on a later one,
   // so valid never gets two assignments in the same time step.
   task automatic send_request(input sks_pkg::req_type r, input bit checked_by_hand,
                               input logic [sks_pkg::STATUS_W-1:0] status);
      int gap;
      gap = pace_random ? $urandom_range(0, MAX_WAIT) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      predict_set_op(r);
      if (checked_by_hand)
         awaited_results.push_back(make_rsp(status, '0, 1'b1));
      else
         foreach (fresh_results[i]) awaited_results.push_back(fresh_results[i]);
   endtask

   task automatic send_op(input logic [sks_pkg::KIND_W-1:0] kind,
                          input logic signed [sks_pkg::KEY_W-1:0] key);
      sks_pkg::req_type r;
      r.kind = kind;
      r.key  = key;
      send_request(r, 1'b0, sks_pkg::STATUS_FAIL);
   endtask

   // A random request as a host might issue it: mostly inserts, deletes and
   // searches, some listings and now and then an undefined kind.
   task automatic send_mixed_op();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         send_op(sks_pkg::KIND_INSERT, draw_key($urandom_range(0, 3) == 0));
      else if (pick < 60)
         send_op(sks_pkg::KIND_DELETE, draw_key($urandom_range(0, 3) != 0));
      else if (pick < 80)
         send_op(sks_pkg::KIND_SEARCH, draw_key($urandom_range(0, 1) != 0));
      else if (pick < 88)
         send_op(sks_pkg::KIND_LIST_ASC, $urandom);
      else if (pick < 96)
         send_op(sks_pkg::KIND_LIST_DESC, $urandom);
      else
         send_op(sks_pkg::KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
                 $urandom);
   endtask

   // The receiver draws a fresh stall length after every accepted result.
   // The stall is applied from the next falling edge, whether or not the
   // next result is already waiting, so stalls land on every phase.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Result checker. Every accepted result is matched against the oldest
   // outstanding prediction, field by field.
   always @(posedge clock) begin
      sks_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_seen++;
         stall_left = pace_random ? $urandom_range(0, MAX_WAIT) : 0;
         if (awaited_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual status %0d key %0d last %0d",
                     $time, rsp_data.status, rsp_data.key_out, rsp_data.last);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_data.status !== want.status) begin
               mismatches++;
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_data.status);
            end
            if (rsp_data.key_out !== want.key_out) begin
               mismatches++;
               $display("%0t: key_out mismatch, expected %0d, actual %0d",
                        $time, want.key_out, rsp_data.key_out);
            end
            if (rsp_data.last !== want.last) begin
               mismatches++;
               $display("%0t: last mismatch, expected %0d, actual %0d",
                        $time, want.last, rsp_data.last);
            end
         end
      end
   end

   // Watchdog: a hang or lost result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles with %0d results still outstanding",
                  $time, CYCLE_LIMIT, awaited_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int round;
      int target;
      sks_pkg::req_type r;

      // Directed table. It starts on the empty store, walks the key
      // extremes, duplicates and absent keys, the undefined kinds, and
      // finally empties the store by deletes and inserts into it again.
      add_row(sks_pkg::KIND_LIST_ASC,  '0,      1'b1, sks_pkg::STATUS_FAIL);
      add_row(sks_pkg::KIND_LIST_DESC, -32'sd1, 1'b1, sks_pkg::STATUS_FAIL);
      add_row(sks_pkg::KIND_SEARCH,    '0,      1'b1, sks_pkg::STATUS_FAIL);
      add_row(sks_pkg::KIND_DELETE,    32'sd5,  1'b1, sks_pkg::STATUS_FAIL);
      add_row(sks_pkg::KIND_INSERT,    '0,      1'b1, sks_pkg::STATUS_OK);
      add_row(sks_pkg::KIND_INSERT,    KEY_MAX, 1'b1, sks_pkg::STATUS_OK);
      add_row(sks_pkg::KIND_INSERT,    KEY_MIN, 1'b1, sks_pkg::STATUS_OK);
      add_row(sks_pkg::KIND_INSERT,    -32'sd1, 1'b1, sks_pkg::STATUS_OK);
      add_row(sks_pkg::KIND_INSERT,    32'sd1,  1'b1, sks_pkg::STATUS_OK);
      add_row(sks_pkg::KIND_INSERT,    '0,      1'b1, sks_pkg::STATUS_FAIL);
      add_row(sks_pkg::KIND_SEARCH,    KEY_MIN, 1'b1, sks_pkg::STATUS_OK);
      add_row(sks_pkg::KIND_SEARCH,    32'sd2,  1'b1, sks_pkg::STATUS_FAIL);
      add_row(sks_pkg::KIND_LIST_ASC,  KEY_MAX, 1'b0, sks_pkg::STATUS_FAIL);
      add_row(sks_pkg::KIND_LIST_DESC, KEY_MIN, 1'b0, sks_pkg::STATUS_FAIL);
      add_row(sks_pkg::KIND_DELETE,    KEY_MAX, 1'b1, sks_pkg::STATUS_OK);
      add_row(sks_pkg::KIND_DELETE,    KEY_MAX, 1'b1, sks_pkg::STATUS_FAIL);
      add_row(KIND_SPARE_FIRST,        -32'sd1, 1'b1, sks_pkg::STATUS_FAIL);
      add_row(KIND_SPARE_MID,          KEY_MIN, 1'b1, sks_pkg::STATUS_FAIL);
      add_row(KIND_SPARE_LAST, 32'sh5555_5555,  1'b1, sks_pkg::STATUS_FAIL);
      add_row(sks_pkg::KIND_DELETE,    KEY_MIN, 1'b1, sks_pkg::STATUS_OK);
      add_row(sks_pkg::KIND_DELETE,    -32'sd1, 1'b1, sks_pkg::STATUS_OK);
      add_row(sks_pkg::KIND_DELETE,    '0,      1'b1, sks_pkg::STATUS_OK);
      add_row(sks_pkg::KIND_DELETE,    32'sd1,  1'b1, sks_pkg::STATUS_OK);
      add_row(sks_pkg::KIND_INSERT,    32'sd42, 1'b1, sks_pkg::STATUS_OK);
      add_row(sks_pkg::KIND_LIST_DESC, '0,      1'b0, sks_pkg::STATUS_FAIL);

      // Synchronous reset, held high from the start and released on a falling edge.
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (directed_plan[i]) begin
         r.kind = directed_plan[i].kind;
         r.key  = directed_plan[i].key;
         send_request(r, directed_plan[i].checked_by_hand, directed_plan[i].status);
      end

      // Random part, in rounds. Fill rounds push the store to capacity,
      // try a duplicate and a fresh key against the full store, list it both
      // ways and then delete most of it again. Mixed rounds behave like a
      // host, and noise rounds hit the refusal paths. Every fourth round
      // runs with no idling on either side. The long loops of a fill round
      // also stop at the request budget.
      round = 0;
      while (requests_sent < ITEM_BUDGET) begin
         pace_random = (round % 4 != 1);
         case (round % 3)
            0: begin
               while (model_keys.size() < sks_pkg::CAPACITY && requests_sent < ITEM_BUDGET)
                  send_op(sks_pkg::KIND_INSERT, draw_key(1'b0));
               send_op(sks_pkg::KIND_INSERT, draw_key(1'b1));
               send_op(sks_pkg::KIND_INSERT, draw_key(1'b0));
               send_op(sks_pkg::KIND_LIST_ASC, $urandom);
               send_op(sks_pkg::KIND_LIST_DESC, $urandom);
               target = $urandom_range(0, 6);
               while (model_keys.size() > target && requests_sent < ITEM_BUDGET)
                  send_op(sks_pkg::KIND_DELETE, draw_key($urandom_range(0, 3) != 0));
            end
            1: begin
               repeat (24) send_mixed_op();
            end
            default: begin
               repeat (12) begin
                  case ($urandom_range(0, 3))
                     0: send_op(sks_pkg::KIND_W'($urandom_range(KIND_SPARE_FIRST,
                                                                 KIND_SPARE_LAST)),
                                $urandom);
                     1: send_op(sks_pkg::KIND_DELETE, draw_key(1'b0));
                     2: send_op(sks_pkg::KIND_INSERT, draw_key(1'b1));
                     default: send_op(sks_pkg::KIND_SEARCH, draw_key(1'b0));
                  endcase
               end
            end
         endcase
         round++;
      end

      @(negedge clock) req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      // A few more cycles so that any stray extra result is caught.
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d results from %0d requests over %0d rounds; %0d mismatches.",
               results_seen, requests_sent, round, mismatches);
      $display("The store reached capacity %0d times and refused %0d inserts as full.",
               fills, full_rejects);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
